// ----- hdl/vertex_viewport_project_defines.svh -----
// Assertion macros shared by the vertex viewport projection block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef VERTEX_VIEWPORT_PROJECT_DEFINES_SVH
`define VERTEX_VIEWPORT_PROJECT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define VVP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define VVP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/vvp_pkg.sv -----
// Shared types, constants and saturation helpers for the viewport projection block.
// Depends on nothing; used by the channel interfaces and the top level.
package vvp_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int FIELD_W           = 32;
   localparam int MAT_DIM           = 4;
   localparam int MAT_ENTRIES       = MAT_DIM * MAT_DIM;
   localparam int MAT_INDEX_W       = $clog2(MAT_ENTRIES);
   localparam int VIEW_POS_W        = 16;
   localparam int VIEW_SIZE_W       = 15;
   localparam int DEPTH_W           = 17;
   localparam int DEPTH_FRAC        = 16;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 17;
   localparam logic [DEPTH_W-1:0] DEPTH_FAR_RESET = DEPTH_W'(65536);

   // Intermediates saturate at +-2^61
   localparam int LIM_EXP = 61;
   localparam int SAT_W   = LIM_EXP + 2;
   localparam int WIDE_W  = 96;
   localparam logic signed [WIDE_W-1:0] LIM_WIDE = WIDE_W'(1) <<< LIM_EXP;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_VERTEX = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VIEW_LEFT   = 3'd0,
      CSR_VIEW_TOP    = 3'd1,
      CSR_VIEW_WIDTH  = 3'd2,
      CSR_VIEW_HEIGHT = 3'd3,
      CSR_DEPTH_NEAR  = 3'd4,
      CSR_DEPTH_FAR   = 3'd5
   } csr_index_type;

   // Clamp a wide signed value to the intermediate range
   function automatic logic signed [SAT_W-1:0] clamp_lim(input logic signed [WIDE_W-1:0] v);
      logic signed [SAT_W-1:0] r;
      if (v > LIM_WIDE) begin
         r = SAT_W'(LIM_WIDE);
      end else if (v < -LIM_WIDE) begin
         r = SAT_W'(-LIM_WIDE);
      end else begin
         r = v[SAT_W-1:0];
      end
      return r;
   endfunction

   // Clamp an intermediate to the signed 32-bit output range
   function automatic logic signed [FIELD_W-1:0] clamp_out(input logic signed [SAT_W-1:0] v);
      logic signed [FIELD_W-1:0] r;
      if (v > SAT_W'(64'sh7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -SAT_W'(64'sh8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[FIELD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/vvp_req_if.sv -----
// Request channel carrying matrix loads and vertices into the projection block.
// Depends on vvp_pkg for field widths and the request kind.
interface vvp_req_if import vvp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   req_kind_type              kind;
   logic [MAT_INDEX_W-1:0]    entry_index;
   logic signed [FIELD_W-1:0] entry_value;
   logic signed [FIELD_W-1:0] pos_x;
   logic signed [FIELD_W-1:0] pos_y;
   logic signed [FIELD_W-1:0] pos_z;

   modport source (output valid, kind, entry_index, entry_value, pos_x, pos_y, pos_z,
                   input ready);
   modport sink (input valid, kind, entry_index, entry_value, pos_x, pos_y, pos_z,
                 output ready);
endinterface

// ----- hdl/vvp_rsp_if.sv -----
// Response channel carrying projected screen positions out of the block.
// Depends on vvp_pkg for field widths.
interface vvp_rsp_if import vvp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] screen_x;
   logic signed [FIELD_W-1:0] screen_y;
   logic signed [FIELD_W-1:0] screen_depth;
   logic                      was_divided;

   modport source (output valid, screen_x, screen_y, screen_depth, was_divided, input ready);
   modport sink (input valid, screen_x, screen_y, screen_depth, was_divided, output ready);
endinterface

// ----- hdl/vertex_viewport_project.sv -----
// Vertex viewport projection: 4x4 transform, perspective divide and viewport map.
// Depends on vvp_pkg, vvp_req_if, vvp_rsp_if and vertex_viewport_project_defines.svh.
//
// Usage: the req_ch channel takes two kinds of request. A load request writes one
// entry (row*4+column) of the transform matrix at the accepting edge and gives no
// response; a vertex request uses the matrix as it stands at that edge. The user must
// write the viewport and depth registers on the csr_ port only while the block is idle;
// the block does not enforce this. Each vertex gives one response on rsp_ch,
// in request order. A vertex passes through three product and setup stages, one
// restoring divider stage per quotient bit for a 66-bit quotient, and six mapping
// and output stages. Throughput: one request per cycle while rsp_ch does not stall.
// Reset clears the pipeline, the matrix and the registers (depth_far to 1.0).
// When rsp_ch stalls, the whole pipeline holds; the entry stage still takes a
// request while it is empty, and nothing is lost or repeated.
`include "vertex_viewport_project_defines.svh"

module vertex_viewport_project import vvp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   vvp_req_if.sink                req_ch,
   vvp_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PROD_W  = 2 * FIELD_W;
   localparam int SHP_W   = PROD_W - FRAC_BITS;
   localparam int CLIP_W  = SHP_W + 2;
   localparam int MAG_W   = CLIP_W;
   localparam int DIV_W   = MAG_W + FRAC_BITS;
   localparam int MUL_W   = SAT_W + DEPTH_W + 1;
   localparam int S_MAG   = 2;
   localparam int S_NORM  = S_MAG + DIV_W + 1;
   localparam int S_BIAS  = S_NORM + 1;
   localparam int S_MUL   = S_BIAS + 1;
   localparam int S_SHIFT = S_MUL + 1;
   localparam int S_OFS   = S_SHIFT + 1;
   localparam int S_OUT   = S_OFS + 1;
   localparam int N_ST    = S_OUT + 1;
   localparam int FLAG_N  = S_OUT - S_NORM + 1;
   localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;
   localparam logic signed [SAT_W-1:0] ONE_SAT = SAT_W'(1) <<< FRAC_BITS;
   localparam logic [DIV_W-1:0] LIM_Q = DIV_W'(1) << LIM_EXP;

   // Configuration registers
   logic signed [VIEW_POS_W-1:0] left_ff, top_ff;
   logic [VIEW_SIZE_W-1:0]       width_ff, height_ff;
   logic [DEPTH_W-1:0]           near_ff, far_ff;

   // Transform matrix, row-major
   logic signed [FIELD_W-1:0] matrix_ff [MAT_ENTRIES];

   // Pipeline control
   logic [N_ST-1:0] v_ff;
   logic            en, ld0, req_fire, vertex_fire;

   // Pipeline payload
   logic signed [PROD_W-1:0]  prod_ff [MAT_ENTRIES-MAT_DIM];
   logic signed [FIELD_W-1:0] bias_ff [MAT_DIM];
   logic signed [FIELD_W-1:0] pos [3];
   logic signed [CLIP_W-1:0]  clip_in [MAT_DIM];
   logic signed [CLIP_W-1:0]  clip_ff [MAT_DIM];
   logic [MAG_W-1:0]          rem_ff [DIV_W+1][3];
   logic [DIV_W-1:0]          dq_ff  [DIV_W+1][3];
   logic [MAG_W-1:0]          dvs_ff [DIV_W+1];
   logic [2:0]                neg_ff [DIV_W+1];
   logic                      div_ff [DIV_W+1];
   logic [MAG_W-1:0]          mag_in [3];
   logic [2:0]                neg_in;
   logic signed [CLIP_W-1:0]  w_val;
   logic [MAG_W-1:0]          w_mag;
   logic                      w_nonzero;
   logic signed [SAT_W-1:0]   n_ff [3];
   logic [FLAG_N-1:0]         flag_ff;
   logic signed [SAT_W-1:0]   ax_ff, ay_ff, nz_ff;
   logic signed [DEPTH_W:0]   depth_span;
   logic signed [MUL_W-1:0]   px_ff, py_ff, pz_ff;
   logic signed [SAT_W-1:0]   sx, sy;
   logic signed [SAT_W-1:0]   tx_ff, ty_ff, tz_ff;
   logic signed [SAT_W-1:0]   ox_ff, oy_ff, oz_ff;
   logic signed [FIELD_W-1:0] rx_ff, ry_ff, rz_ff;

   // Handshake: hold everything while the output waits; fill an empty entry stage
   assign en          = !(v_ff[S_OUT] && !rsp_ch.ready);
   assign ld0         = en || !v_ff[0];
   assign req_ch.ready = ld0;
   assign req_fire    = req_ch.valid && ld0;
   assign vertex_fire = req_fire && (req_ch.kind == KIND_VERTEX);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         near_ff   <= '0;
         far_ff    <= DEPTH_FAR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VIEW_LEFT:   left_ff   <= csr_wdata[VIEW_POS_W-1:0];
            CSR_VIEW_TOP:    top_ff    <= csr_wdata[VIEW_POS_W-1:0];
            CSR_VIEW_WIDTH:  width_ff  <= csr_wdata[VIEW_SIZE_W-1:0];
            CSR_VIEW_HEIGHT: height_ff <= csr_wdata[VIEW_SIZE_W-1:0];
            CSR_DEPTH_NEAR:  near_ff   <= csr_wdata[DEPTH_W-1:0];
            CSR_DEPTH_FAR:   far_ff    <= csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Load matrix entries
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_ENTRIES; i++) matrix_ff[i] <= '0;
      end else if (req_fire && (req_ch.kind == KIND_LOAD)) begin
         matrix_ff[req_ch.entry_index] <= req_ch.entry_value;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld0) v_ff[0] <= vertex_fire;
         if (en) v_ff[N_ST-1:1] <= v_ff[N_ST-2:0];
      end
   end

   assign pos[0] = req_ch.pos_x;
   assign pos[1] = req_ch.pos_y;
   assign pos[2] = req_ch.pos_z;

   // Stage 0: row-vector products against the matrix
   always_ff @(posedge clock) begin
      if (ld0) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < MAT_DIM; c++) begin
               prod_ff[r*MAT_DIM+c] <= pos[r] * matrix_ff[r*MAT_DIM+c];
            end
         end
         for (int c = 0; c < MAT_DIM; c++) bias_ff[c] <= matrix_ff[3*MAT_DIM+c];
      end
   end

   // Stage 1: floor each product to the fixed-point grid and sum the column
   always_comb begin
      for (int c = 0; c < MAT_DIM; c++) begin
         clip_in[c] = CLIP_W'(bias_ff[c])
                    + CLIP_W'(prod_ff[c] >>> FRAC_BITS)
                    + CLIP_W'(prod_ff[MAT_DIM+c] >>> FRAC_BITS)
                    + CLIP_W'(prod_ff[2*MAT_DIM+c] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < MAT_DIM; c++) clip_ff[c] <= clip_in[c];
      end
   end

   // Stage 2: split into sign and magnitude; zero w divides by one instead
   always_comb begin
      w_val     = clip_ff[MAT_DIM-1];
      w_nonzero = (w_val != '0);
      w_mag     = w_val[CLIP_W-1] ? MAG_W'(-w_val) : MAG_W'(w_val);
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = clip_ff[i][CLIP_W-1] ? MAG_W'(-clip_ff[i]) : MAG_W'(clip_ff[i]);
         neg_in[i] = clip_ff[i][CLIP_W-1] ^ (w_nonzero && w_val[CLIP_W-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= '0;
            dq_ff[0][i]  <= {mag_in[i], {FRAC_BITS{1'b0}}};
         end
         dvs_ff[0] <= w_nonzero ? w_mag : ONE_MAG;
         neg_ff[0] <= neg_in;
         div_ff[0] <= w_nonzero;
      end
   end

   // Restoring divider: one quotient bit per stage for all three lanes
   for (genvar k = 1; k <= DIV_W; k++) begin : g_div
      logic [MAG_W:0] trial [3];
      logic [MAG_W:0] diff  [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            trial[i] = {rem_ff[k-1][i], dq_ff[k-1][i][DIV_W-1]};
            diff[i]  = trial[i] - {1'b0, dvs_ff[k-1]};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if (!diff[i][MAG_W]) begin
                  rem_ff[k][i] <= diff[i][MAG_W-1:0];
                  dq_ff[k][i]  <= {dq_ff[k-1][i][DIV_W-2:0], 1'b1};
               end else begin
                  rem_ff[k][i] <= trial[i][MAG_W-1:0];
                  dq_ff[k][i]  <= {dq_ff[k-1][i][DIV_W-2:0], 1'b0};
               end
            end
            dvs_ff[k] <= dvs_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            div_ff[k] <= div_ff[k-1];
         end
      end
   end

   // Normalize: saturate the quotient and restore its sign
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dq_ff[DIV_W][i] > LIM_Q) begin
               n_ff[i] <= neg_ff[DIV_W][i] ? -SAT_W'(LIM_Q) : SAT_W'(LIM_Q);
            end else begin
               n_ff[i] <= neg_ff[DIV_W][i] ? -SAT_W'(dq_ff[DIV_W][i])
                                           : SAT_W'(dq_ff[DIV_W][i]);
            end
         end
      end
   end

   // Carry the divide flag alongside the mapping stages
   always_ff @(posedge clock) begin
      if (en) flag_ff <= {flag_ff[FLAG_N-2:0], div_ff[DIV_W]};
   end

   // Bias x and flipped y by one
   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= clamp_lim(WIDE_W'(n_ff[0]) + WIDE_W'(ONE_SAT));
         ay_ff <= clamp_lim(WIDE_W'(ONE_SAT) - WIDE_W'(n_ff[1]));
         nz_ff <= n_ff[2];
      end
   end

   // Scale by viewport size and depth span
   assign depth_span = $signed({1'b0, far_ff}) - $signed({1'b0, near_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= ax_ff * $signed({1'b0, width_ff});
         py_ff <= ay_ff * $signed({1'b0, height_ff});
         pz_ff <= nz_ff * depth_span;
      end
   end

   // Saturate products and halve x and y
   assign sx = clamp_lim(WIDE_W'(px_ff));
   assign sy = clamp_lim(WIDE_W'(py_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff <= sx >>> 1;
         ty_ff <= sy >>> 1;
         tz_ff <= clamp_lim(WIDE_W'(pz_ff));
      end
   end

   // Add viewport origin and near depth
   always_ff @(posedge clock) begin
      if (en) begin
         ox_ff <= clamp_lim(WIDE_W'(tx_ff) + (WIDE_W'(left_ff) <<< FRAC_BITS));
         oy_ff <= clamp_lim(WIDE_W'(ty_ff) + (WIDE_W'(top_ff) <<< FRAC_BITS));
         oz_ff <= clamp_lim(WIDE_W'(tz_ff)
                            + ($signed(WIDE_W'(near_ff)) <<< FRAC_BITS));
      end
   end

   // Output register: saturate to 32 bits, rescale depth
   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff <= clamp_out(ox_ff);
         ry_ff <= clamp_out(oy_ff);
         rz_ff <= clamp_out(oz_ff >>> DEPTH_FRAC);
      end
   end

   assign rsp_ch.valid        = v_ff[S_OUT];
   assign rsp_ch.screen_x     = rx_ff;
   assign rsp_ch.screen_y     = ry_ff;
   assign rsp_ch.screen_depth = rz_ff;
   assign rsp_ch.was_divided  = flag_ff[FLAG_N-1];

   // A load never places a vertex in the entry stage
   `VVP_ASSERT_NEXT(a_load_no_vertex, clock, reset, req_fire && (req_ch.kind == KIND_LOAD), !v_ff[0], "load request entered the pipeline")
   // A held response stays valid through the stall
   `VVP_ASSERT_NEXT(a_stall_holds, clock, reset, !en, v_ff[S_OUT], "stalled response dropped")
   // A load lands in the addressed matrix entry
   `VVP_ASSERT_NEXT(a_load_written, clock, reset, req_fire && (req_ch.kind == KIND_LOAD), matrix_ff[$past(req_ch.entry_index)] == $past(req_ch.entry_value), "matrix entry not written")
   // A stalled pipeline refuses requests only when its entry stage is full
   `VVP_ASSERT_NOW(a_ready_when_empty, clock, reset, !v_ff[0], req_ch.ready, "entry stage empty but not ready")

endmodule
